[rtl/cis_pkg.sv]
// Shared types, codes and constants of the CBOR item skip scanner.
package cis_pkg;

  localparam int MAX_NEST    = 16;
  localparam int LENGTH_BITS = 32;
  localparam int STACK_W     = 33;
  localparam int LIMIT_W     = 5;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic               REG_LIMIT   = 1'b0;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MALFORMED = 2'd1;
  localparam logic [1:0] STAT_TAG       = 2'd2;

  localparam logic [2:0] MAJ_BSTR  = 3'd2;
  localparam logic [2:0] MAJ_TSTR  = 3'd3;
  localparam logic [2:0] MAJ_ARRAY = 3'd4;
  localparam logic [2:0] MAJ_MAP   = 3'd5;
  localparam logic [2:0] MAJ_TAG   = 3'd6;

  localparam logic [4:0] AI_EXT1 = 5'd24;
  localparam logic [4:0] AI_EXT2 = 5'd25;
  localparam logic [4:0] AI_EXT4 = 5'd26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } cis_in_t;

  typedef struct packed {
    logic [1:0]  scan_status;
    logic [31:0] consumed_length;
  } cis_out_t;

  typedef struct packed {
    logic     valid;
    cis_out_t res;
  } cis_emit_t;

endpackage

[rtl/cbor_item_skip_scanner.sv]
// Top level of the CBOR item skip scanner: register port, core and result queue.
//
// Usage: bytes of an encoded buffer enter on the in_ channel, one request per byte,
// with first_byte marking the start of a buffer and last_byte its end. For each
// buffer one result request leaves on the out_ channel: status and the length of
// the first data item. Bytes after the result, up to the next first_byte, are
// taken and dropped. The nesting limit is set through the APB port at address 0.
// Throughput: one byte per cycle. Each container that a byte closes while an
// enclosing container stays open costs a read of the nesting stack memory
// (registered read), and input stalls during it; closing the outer item costs none.
// The result is registered in the result queue once the byte that completes the
// scan, or the last stack read, is processed.
// Reset clears the scan, empties the result queue and sets the limit to 16.
// Results queue in two entries; input stalls while the second one is occupied,
// which only a stalling receiver causes.
module cbor_item_skip_scanner #(
  parameter int MAX_NEST    = cis_pkg::MAX_NEST,
  parameter int LENGTH_BITS = cis_pkg::LENGTH_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cis_pkg::cis_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cis_pkg::cis_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cis_pkg::APB_AW-1:0]  paddr,
  input  logic [cis_pkg::APB_DW-1:0]  pwdata,
  output logic [cis_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [cis_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic                        q_full;
  cis_pkg::cis_emit_t          emit;

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && (paddr[2] == cis_pkg::REG_LIMIT)) begin
      limit_nxt = pwdata[cis_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cis_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cis_pkg::REG_LIMIT) ? cis_pkg::APB_DW'(limit_r) : '0;

  cis_ctrl #(
    .MAX_NEST    (MAX_NEST),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .limit    (limit_r),
    .q_full   (q_full),
    .emit     (emit)
  );

  cis_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/cis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/cis_outq.sv]
// Two-entry result queue between the scanner core and the result channel.
module cis_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  cis_pkg::cis_emit_t  emit,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output cis_pkg::cis_out_t   out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  cis_pkg::cis_out_t out_data_r, out_data_nxt;
  cis_pkg::cis_out_t hold_data_r, hold_data_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    hold_valid_nxt = hold_valid_r;
    out_data_nxt   = out_data_r;
    hold_data_nxt  = hold_data_r;
    if (slot_free) begin
      if (hold_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = hold_data_r;
        hold_valid_nxt = emit.valid;
        hold_data_nxt  = emit.res;
      end else begin
        out_valid_nxt = emit.valid;
        out_data_nxt  = emit.res;
      end
    end else if (emit.valid) begin
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = emit.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign full      = hold_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/cis_ctrl.sv]
// Scanner core: head decode, payload skip and container stack sequencing.
module cis_ctrl #(
  parameter int MAX_NEST    = cis_pkg::MAX_NEST,
  parameter int LENGTH_BITS = cis_pkg::LENGTH_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cis_pkg::cis_in_t              in_data,
  input  logic [cis_pkg::LIMIT_W-1:0]   limit,
  input  logic                          q_full,
  output cis_pkg::cis_emit_t            emit
);

  localparam int NEST_W = $clog2(MAX_NEST + 2);
  localparam int AW     = $clog2(MAX_NEST + 1);
  localparam int CMP_W  = (NEST_W > cis_pkg::LIMIT_W) ? NEST_W : cis_pkg::LIMIT_W;
  localparam int SW     = cis_pkg::STACK_W;

  typedef enum logic [3:0] {
    PH_HEAD    = 4'b0001,
    PH_EXT     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_POP     = 4'b1000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic                   given_r, given_nxt;
  logic [NEST_W-1:0]      level_r, level_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [2:0]             major_r, major_nxt;
  logic [2:0]             ext_r, ext_nxt;
  logic [31:0]            hv_r, hv_nxt;
  logic [31:0]            pl_r, pl_nxt;
  logic [SW-1:0]          tos_r, tos_nxt;
  logic                   lastp_r, lastp_nxt;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [SW-1:0]          mem_wdata, mem_rdata;

  logic                   in_acc;
  logic [CMP_W-1:0]       lim_c;
  logic                   do_head, do_item, go_pop, cur_last;
  logic [SW-1:0]          item_top, dec, child_n;
  logic [4:0]             ai;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (phase_r == PH_POP) || q_full;
  assign lim_c    = (CMP_W'(limit) > CMP_W'(MAX_NEST)) ? CMP_W'(MAX_NEST) : CMP_W'(limit);
  assign ai       = in_data.data_byte[4:0];

  always_comb begin
    phase_nxt  = phase_r;
    given_nxt  = given_r;
    level_nxt  = level_r;
    count_nxt  = count_r;
    major_nxt  = major_r;
    ext_nxt    = ext_r;
    hv_nxt     = hv_r;
    pl_nxt     = pl_r;
    tos_nxt    = tos_r;
    lastp_nxt  = lastp_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = '0;
    mem_raddr  = '0;
    mem_wdata  = tos_r;
    do_head    = 1'b0;
    do_item    = 1'b0;
    go_pop     = 1'b0;
    cur_last   = 1'b0;
    item_top   = tos_r;
    emit       = '0;

    if (phase_r == PH_POP) begin
      do_item  = 1'b1;
      item_top = mem_rdata;
      cur_last = lastp_r;
    end else if (in_acc) begin
      if (in_data.first_byte) begin
        phase_nxt = PH_HEAD;
        given_nxt = 1'b0;
        level_nxt = '0;
        count_nxt = '0;
        major_nxt = '0;
        ext_nxt   = '0;
        hv_nxt    = '0;
        pl_nxt    = '0;
      end
      if (!given_nxt) begin
        cur_last = in_data.last_byte;
        if (count_nxt == '1) begin
          emit.valid           = 1'b1;
          emit.res.scan_status = cis_pkg::STAT_MALFORMED;
        end else begin
          count_nxt = count_nxt + LENGTH_BITS'(1);
          unique case (phase_nxt)
            PH_EXT: begin
              hv_nxt  = {hv_nxt[23:0], in_data.data_byte};
              ext_nxt = ext_nxt - 3'd1;
              do_head = (ext_nxt == 3'd0);
            end
            PH_PAYLOAD: begin
              pl_nxt  = pl_nxt - 32'd1;
              do_item = (pl_nxt == 32'd0);
            end
            default: begin
              if (CMP_W'(level_nxt) > lim_c) begin
                emit.valid           = 1'b1;
                emit.res.scan_status = cis_pkg::STAT_MALFORMED;
              end else begin
                major_nxt = in_data.data_byte[7:5];
                if (ai < cis_pkg::AI_EXT1) begin
                  hv_nxt  = 32'(ai);
                  do_head = 1'b1;
                end else if (ai > cis_pkg::AI_EXT4) begin
                  emit.valid           = 1'b1;
                  emit.res.scan_status = cis_pkg::STAT_MALFORMED;
                end else begin
                  hv_nxt    = '0;
                  ext_nxt   = (ai == cis_pkg::AI_EXT1) ? 3'd1 :
                              (ai == cis_pkg::AI_EXT2) ? 3'd2 : 3'd4;
                  phase_nxt = PH_EXT;
                end
              end
            end
          endcase
        end
      end
    end

    child_n = (major_nxt == cis_pkg::MAJ_MAP) ? {hv_nxt, 1'b0} : {1'b0, hv_nxt};

    if (do_head) begin
      unique case (major_nxt) inside
        cis_pkg::MAJ_BSTR, cis_pkg::MAJ_TSTR: begin
          if (hv_nxt == 32'd0) begin
            do_item = 1'b1;
          end else begin
            pl_nxt    = hv_nxt;
            phase_nxt = PH_PAYLOAD;
          end
        end
        cis_pkg::MAJ_ARRAY, cis_pkg::MAJ_MAP: begin
          if (child_n == '0) begin
            do_item = 1'b1;
          end else if (level_nxt > NEST_W'(MAX_NEST)) begin
            emit.valid           = 1'b1;
            emit.res.scan_status = cis_pkg::STAT_MALFORMED;
          end else begin
            if (level_nxt != '0) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(level_nxt - NEST_W'(1));
            end
            tos_nxt   = child_n;
            level_nxt = level_nxt + NEST_W'(1);
            phase_nxt = PH_HEAD;
          end
        end
        cis_pkg::MAJ_TAG: begin
          emit.valid           = 1'b1;
          emit.res.scan_status = (level_nxt == '0) ? cis_pkg::STAT_TAG
                                                   : cis_pkg::STAT_MALFORMED;
        end
        default: begin
          do_item = 1'b1;
        end
      endcase
    end

    dec = item_top - SW'(1);

    if (do_item) begin
      if (level_nxt == '0) begin
        emit.valid           = 1'b1;
        emit.res.scan_status = cis_pkg::STAT_OK;
      end else if (dec != '0) begin
        tos_nxt   = dec;
        phase_nxt = PH_HEAD;
      end else begin
        level_nxt = level_nxt - NEST_W'(1);
        if (level_nxt == '0) begin
          emit.valid           = 1'b1;
          emit.res.scan_status = cis_pkg::STAT_OK;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(level_nxt - NEST_W'(1));
          phase_nxt = PH_POP;
          go_pop    = 1'b1;
          lastp_nxt = cur_last;
        end
      end
    end

    if (!emit.valid && !go_pop && cur_last) begin
      emit.valid           = 1'b1;
      emit.res.scan_status = cis_pkg::STAT_MALFORMED;
    end

    if (emit.valid) begin
      phase_nxt = PH_HEAD;
      given_nxt = 1'b1;
      emit.res.consumed_length = (emit.res.scan_status == cis_pkg::STAT_OK) ?
                                 32'(count_nxt) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      given_r <= 1'b0;
      level_r <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      given_r <= given_nxt;
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
    major_r <= major_nxt;
    ext_r   <= ext_nxt;
    hv_r    <= hv_nxt;
    pl_r    <= pl_nxt;
    tos_r   <= tos_nxt;
    lastp_r <= lastp_nxt;
  end

  cis_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_NEST + 1)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
